// ===== design/nmea_rmc_field_parser_defines.svh =====
// Assertion macros shared by the NMEA RMC field parser.
`ifndef NMEA_RMC_FIELD_PARSER_DEFINES_SVH
`define NMEA_RMC_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NRMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NRMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/nrmc_pkg.sv =====
// Package: parse phases, character codes, result type and helpers of the RMC parser.
package nrmc_pkg;

   localparam int MAX_SPEED_CHARS_DEF = 5;
   localparam int SPEED_REPORT_MAX    = 5;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_HDRSKIP = 4'd1,
      PH_TIME    = 4'd2,
      PH_TSKIP   = 4'd3,
      PH_STATUS  = 4'd4,
      PH_LATSEP  = 4'd5,
      PH_LAT     = 4'd6,
      PH_LONSEP  = 4'd7,
      PH_LON     = 4'd8,
      PH_SPDSEP  = 4'd9,
      PH_SPEED   = 4'd10,
      PH_SPDEND  = 4'd11,
      PH_COURSE  = 4'd12,
      PH_DATE    = 4'd13
   } phase_type;

   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_POINT  = 8'h2E;
   localparam logic [7:0] CHR_A      = 8'h41;
   localparam logic [7:0] CHR_V      = 8'h56;

   localparam logic [1:0] FIX_VALID   = 2'd0;
   localparam logic [1:0] FIX_INVALID = 2'd1;
   localparam logic [1:0] FIX_UNKNOWN = 2'd2;

   typedef struct packed {
      logic [39:0] time_high;
      logic [39:0] time_low;
      logic [27:0] latitude_bcd;
      logic [31:0] longitude_bcd;
      logic [39:0] speed_text;
      logic [2:0]  speed_length;
      logic [23:0] date_bcd;
      logic [1:0]  fix_status;
   } result_type;

   // Characters of the "$GPRMC" header by position.
   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] chr;
      case (idx)
         3'd0:    chr = CHR_DOLLAR;
         3'd1:    chr = 8'h47;
         3'd2:    chr = 8'h50;
         3'd3:    chr = 8'h52;
         3'd4:    chr = 8'h4D;
         3'd5:    chr = 8'h43;
         default: chr = 8'h00;
      endcase
      return chr;
   endfunction

   function automatic logic is_dec(input logic [7:0] chr);
      return (chr >= 8'h30) && (chr <= 8'h39);
   endfunction

endpackage

// ===== design/nrmc_if.sv =====
// Valid/ready channel interfaces for received bytes and parsed sentence results.
interface nrmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [39:0] time_high;
   logic [39:0] time_low;
   logic [27:0] latitude_bcd;
   logic [31:0] longitude_bcd;
   logic [39:0] speed_text;
   logic [2:0]  speed_length;
   logic [23:0] date_bcd;
   logic [1:0]  fix_status;

   modport source (output valid, output time_high, output time_low, output latitude_bcd,
                   output longitude_bcd, output speed_text, output speed_length,
                   output date_bcd, output fix_status, input ready);
   modport sink   (input valid, input time_high, input time_low, input latitude_bcd,
                   input longitude_bcd, input speed_text, input speed_length,
                   input date_bcd, input fix_status, output ready);
endinterface

// ===== design/nrmc_parser.sv =====
// Sentence parser: phase register, field captures and result assembly for one byte.
module nrmc_parser import nrmc_pkg::*; #(
   parameter int MAX_SPEED_CHARS = MAX_SPEED_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       emit,
   output result_type result
);

   localparam int SPD_KEEP  = (MAX_SPEED_CHARS < SPEED_REPORT_MAX) ?
                              MAX_SPEED_CHARS : SPEED_REPORT_MAX;
   localparam int SPD_CNT_W = $clog2(MAX_SPEED_CHARS + 1);

   phase_type            phase_ff, phase_in;
   logic [3:0]           pos_ff, pos_in;
   logic [7:0]           time_ff [10];
   logic [7:0]           time_in [10];
   logic [3:0]           lat_ff [7];
   logic [3:0]           lat_in [7];
   logic [3:0]           lon_ff [8];
   logic [3:0]           lon_in [8];
   logic [7:0]           spd_ff [SPD_KEEP];
   logic [7:0]           spd_in [SPD_KEEP];
   logic [SPD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]           date_ff [6];
   logic [3:0]           date_in [6];
   logic                 fmt_ok_ff, fmt_ok_in;
   logic [1:0]           status_code;
   logic [2:0]           lat_idx, lon_idx;
   logic [3:0]           pos_inc;
   logic [SPD_CNT_W-1:0] cnt_inc;
   logic [2:0]           spd_len;

   assign pos_inc = pos_ff + 4'd1;
   assign cnt_inc = cnt_ff + SPD_CNT_W'(1);
   assign lat_idx = (pos_ff < 4'd4) ? pos_ff[2:0] : 3'(pos_ff - 4'd1);
   assign lon_idx = (pos_ff < 4'd5) ? pos_ff[2:0] : 3'(pos_ff - 4'd1);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      time_in     = time_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      spd_in      = spd_ff;
      cnt_in      = cnt_ff;
      date_in     = date_ff;
      fmt_ok_in   = fmt_ok_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (pos_ff < 4'd6 && rx_byte == header_char(pos_ff[2:0])) begin
               if (pos_ff == 4'd5) begin
                  // Header complete: start a fresh capture.
                  for (int k = 0; k < 10; k++) time_in[k] = 8'h00;
                  for (int k = 0; k < 7; k++) lat_in[k] = 4'h0;
                  for (int k = 0; k < 8; k++) lon_in[k] = 4'h0;
                  for (int k = 0; k < SPD_KEEP; k++) spd_in[k] = 8'h00;
                  for (int k = 0; k < 6; k++) date_in[k] = 4'h0;
                  cnt_in    = '0;
                  fmt_ok_in = 1'b1;
                  phase_in  = PH_HDRSKIP;
                  pos_in    = 4'd0;
               end else begin
                  pos_in = pos_inc;
               end
            end else begin
               pos_in = (rx_byte == CHR_DOLLAR) ? 4'd1 : 4'd0;
            end
         end
         PH_HDRSKIP: begin
            phase_in = PH_TIME;
            pos_in   = 4'd0;
         end
         PH_TIME: begin
            if (pos_ff < 4'd10) time_in[pos_ff] = rx_byte;
            pos_in = pos_inc;
            if (pos_inc >= 4'd10) begin
               phase_in = PH_TSKIP;
               pos_in   = 4'd0;
            end
         end
         PH_TSKIP: begin
            phase_in = PH_STATUS;
         end
         PH_STATUS: begin
            if (rx_byte == CHR_A) begin
               phase_in = PH_LATSEP;
            end else begin
               phase_in    = PH_HUNT;
               pos_in      = 4'd0;
            end
         end
         PH_LATSEP: begin
            phase_in = PH_LAT;
            pos_in   = 4'd0;
         end
         PH_LAT: begin
            if (pos_ff == 4'd4) begin
               if (rx_byte != CHR_POINT) fmt_ok_in = 1'b0;
            end else if (pos_ff < 4'd8) begin
               if (!is_dec(rx_byte)) fmt_ok_in = 1'b0;
               lat_in[lat_idx] = rx_byte[3:0];
            end
            pos_in = pos_inc;
            if (pos_inc >= 4'd8) begin
               phase_in = PH_LONSEP;
               pos_in   = 4'd0;
            end
         end
         PH_LONSEP: begin
            pos_in = pos_inc;
            if (pos_inc >= 4'd3) begin
               phase_in = PH_LON;
               pos_in   = 4'd0;
            end
         end
         PH_LON: begin
            if (pos_ff == 4'd5) begin
               if (rx_byte != CHR_POINT) fmt_ok_in = 1'b0;
            end else if (pos_ff < 4'd9) begin
               if (!is_dec(rx_byte)) fmt_ok_in = 1'b0;
               lon_in[lon_idx] = rx_byte[3:0];
            end
            pos_in = pos_inc;
            if (pos_inc >= 4'd9) begin
               phase_in = PH_SPDSEP;
               pos_in   = 4'd0;
            end
         end
         PH_SPDSEP: begin
            pos_in = pos_inc;
            if (pos_inc >= 4'd3) begin
               phase_in = PH_SPEED;
               pos_in   = 4'd0;
               cnt_in   = '0;
            end
         end
         PH_SPEED: begin
            if (rx_byte == CHR_COMMA) begin
               phase_in = PH_COURSE;
               pos_in   = 4'd0;
            end else begin
               for (int k = 0; k < SPD_KEEP; k++) begin
                  if (cnt_ff == SPD_CNT_W'(k)) spd_in[k] = rx_byte;
               end
               cnt_in = cnt_inc;
               if (cnt_inc >= SPD_CNT_W'(MAX_SPEED_CHARS)) phase_in = PH_SPDEND;
            end
         end
         PH_SPDEND: begin
            phase_in = PH_COURSE;
            pos_in   = 4'd0;
         end
         PH_COURSE: begin
            pos_in = pos_inc;
            if (rx_byte == CHR_COMMA || pos_inc >= 4'd6) begin
               phase_in = PH_DATE;
               pos_in   = 4'd0;
            end
         end
         PH_DATE: begin
            if (!is_dec(rx_byte)) fmt_ok_in = 1'b0;
            if (pos_ff < 4'd6) date_in[pos_ff[2:0]] = rx_byte[3:0];
            pos_in = pos_inc;
            if (pos_inc >= 4'd6) begin
               phase_in    = PH_HUNT;
               pos_in      = 4'd0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            pos_in   = 4'd0;
         end
      endcase
   end

   // Raise the result strobe on the byte that closes a sentence.
   always_comb begin
      emit        = 1'b0;
      status_code = FIX_VALID;
      unique case (phase_ff)
         PH_STATUS: begin
            if (rx_byte != CHR_A) begin
               emit        = 1'b1;
               status_code = (rx_byte == CHR_V) ? FIX_INVALID : FIX_UNKNOWN;
            end
         end
         PH_DATE: begin
            if (pos_inc >= 4'd6) begin
               emit        = 1'b1;
               status_code = fmt_ok_in ? FIX_VALID : FIX_INVALID;
            end
         end
         default: begin
            emit        = 1'b0;
            status_code = FIX_VALID;
         end
      endcase
   end

   // Assemble the result from the post-update capture.
   assign spd_len = (cnt_in > SPD_CNT_W'(SPD_KEEP)) ? 3'(SPD_KEEP) : 3'(cnt_in);

   always_comb begin
      result = '0;
      for (int k = 0; k < 5; k++) begin
         result.time_high[39-8*k -: 8] = time_in[k];
         result.time_low[39-8*k -: 8]  = time_in[k+5];
      end
      for (int k = 0; k < 7; k++) result.latitude_bcd[27-4*k -: 4] = lat_in[k];
      for (int k = 0; k < 8; k++) result.longitude_bcd[31-4*k -: 4] = lon_in[k];
      for (int k = 0; k < SPD_KEEP; k++) begin
         if (3'(k) < spd_len) result.speed_text[39-8*k -: 8] = spd_in[k];
      end
      result.speed_length = spd_len;
      for (int k = 0; k < 6; k++) result.date_bcd[23-4*k -: 4] = date_in[k];
      result.fix_status = status_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= 4'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         time_ff   <= time_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         spd_ff    <= spd_in;
         cnt_ff    <= cnt_in;
         date_ff   <= date_in;
         fmt_ok_ff <= fmt_ok_in;
      end
   end

endmodule

// ===== design/nrmc_result_reg.sv =====
// Result register: holds one finished sentence result until the sink takes it.
module nrmc_result_reg import nrmc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       out_ready,
   output logic       out_valid,
   output result_type out_data
);

   logic       vld_ff, vld_in;
   result_type data_ff;

   assign vld_in = load | (vld_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/nmea_rmc_field_parser.sv =====
// An accepted byte waits in the input register until parsed; a finished result is registered.
// Throughput: one byte per cycle; the input register advances every cycle except when
//   the byte would finish a sentence while the result register still holds an untaken item.
// Reset (synchronous, active high): header hunt, empty input and result registers.
// Captured fields are cleared whenever a new "$GPRMC" header is matched.
`include "nmea_rmc_field_parser_defines.svh"

module nmea_rmc_field_parser import nrmc_pkg::*; #(
   parameter int MAX_SPEED_CHARS = MAX_SPEED_CHARS_DEF
) (
   input logic         clock,
   input logic         reset,
   nrmc_req_if.sink    req_chan,
   nrmc_rsp_if.source  rsp_chan
);

   // Input register: one received byte waiting for the parser.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;

   logic       emit;
   logic       slot_free;
   logic       advance;
   logic       req_take;
   result_type parsed;
   result_type held;

   // The result slot is free when empty or being drained this cycle.
   assign slot_free = ~rsp_chan.valid | rsp_chan.ready;

   // Advance the parser unless the byte would finish a sentence into a full slot.
   assign advance = in_vld_ff & (~emit | slot_free);

   // Take a new byte whenever the input register is empty or moves on.
   assign req_chan.ready = ~in_vld_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   assign in_vld_in = req_take | (in_vld_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // Parse phase, field captures and result assembly.
   nrmc_parser #(
      .MAX_SPEED_CHARS (MAX_SPEED_CHARS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (parsed)
   );

   // Hold the finished item for the result channel.
   nrmc_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (advance & emit),
      .load_data (parsed),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (held)
   );

   assign rsp_chan.time_high     = held.time_high;
   assign rsp_chan.time_low      = held.time_low;
   assign rsp_chan.latitude_bcd  = held.latitude_bcd;
   assign rsp_chan.longitude_bcd = held.longitude_bcd;
   assign rsp_chan.speed_text    = held.speed_text;
   assign rsp_chan.speed_length  = held.speed_length;
   assign rsp_chan.date_bcd      = held.date_bcd;
   assign rsp_chan.fix_status    = held.fix_status;

   // A free result slot never backs up the byte stream.
   `NRMC_ASSERT_NOW(a_no_stall_when_free, clock, reset, slot_free, req_chan.ready, "input stalled with free result slot")

   // Only the three defined fix codes leave the block.
   `NRMC_ASSERT_NOW(a_fix_code, clock, reset, rsp_chan.valid, (rsp_chan.fix_status == FIX_VALID || rsp_chan.fix_status == FIX_INVALID || rsp_chan.fix_status == FIX_UNKNOWN), "undefined fix code")

   // An unknown status ends the sentence before any field after it is captured.
   `NRMC_ASSERT_NOW(a_unknown_empty, clock, reset, (rsp_chan.valid && rsp_chan.fix_status == FIX_UNKNOWN), (rsp_chan.speed_length == 3'd0 && rsp_chan.date_bcd == 24'd0 && rsp_chan.latitude_bcd == 28'd0), "unknown status with captured fields")

   // A stalled result keeps its slot occupied in the next cycle.
   `NRMC_ASSERT_NEXT(a_stall_holds_slot, clock, reset, (rsp_chan.valid && !rsp_chan.ready), rsp_chan.valid, "stalled result dropped")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the NMEA RMC field parser: byte stream in, parsed fixes out.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nrmc_pkg::*;

   localparam int SPEED_MAX     = MAX_SPEED_CHARS_DEF;
   localparam int STREAM_BYTES  = 1900;  // at least this many bytes queued in total
   localparam int RANDOM_LINES  = 25;    // and at least this many random sentences
   localparam int GAP_MAX       = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES  = 400000;

   localparam logic [7:0] CHR_ZERO = "0";
   localparam logic [7:0] RMC_HEADER [6] = '{CHR_DOLLAR, "G", "P", "R", "M", "C"};

   typedef struct {
      logic [7:0] chr;
      bit         drain_first;  // hold this byte until every fix has come back
   } rx_char_type;

   logic clock = 1'b0;
   logic reset;

   nrmc_req_if req_bus ();
   nrmc_rsp_if rsp_bus ();

   nmea_rmc_field_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Sentence predictor: mirrors the parser state one accepted byte at a time.
   // ---------------------------------------------------------------------------
   phase_type   scan_phase;
   logic [3:0]  scan_pos;
   logic [7:0]  stamp_chars [10];
   logic [3:0]  lat_nib [7];
   logic [3:0]  lon_nib [8];
   logic [7:0]  speed_buf [SPEED_MAX];
   logic [2:0]  speed_cnt;
   logic [3:0]  date_nib [6];
   bit          fields_ok;

   // Clear every captured field; done at reset and on each header match.
   function automatic void wipe_capture();
      foreach (stamp_chars[k]) stamp_chars[k] = '0;
      foreach (lat_nib[k]) lat_nib[k] = '0;
      foreach (lon_nib[k]) lon_nib[k] = '0;
      foreach (speed_buf[k]) speed_buf[k] = '0;
      foreach (date_nib[k]) date_nib[k] = '0;
      speed_cnt = '0;
      fields_ok = 1'b1;
   endfunction

   function automatic bit ascii_digit(input logic [7:0] chr);
      return (chr >= "0") && (chr <= "9");
   endfunction

   // Assemble the fix record from whatever has been captured so far.
   function automatic result_type pack_fix(input logic [1:0] status);
      result_type f;
      int         len;
      f = '0;
      for (int k = 0; k < 5; k++) begin
         f.time_high = {f.time_high[31:0], stamp_chars[k]};
         f.time_low  = {f.time_low[31:0], stamp_chars[k + 5]};
      end
      for (int k = 0; k < 7; k++) f.latitude_bcd = {f.latitude_bcd[23:0], lat_nib[k]};
      for (int k = 0; k < 8; k++) f.longitude_bcd = {f.longitude_bcd[27:0], lon_nib[k]};
      for (int k = 0; k < 6; k++) f.date_bcd = {f.date_bcd[19:0], date_nib[k]};
      // Saturate the reported speed length; only the first characters are kept.
      len = (speed_cnt > SPEED_REPORT_MAX) ? SPEED_REPORT_MAX : int'(speed_cnt);
      if (len > SPEED_MAX) len = SPEED_MAX;
      for (int k = 0; k < len; k++) f.speed_text[39 - 8 * k -: 8] = speed_buf[k];
      f.speed_length = 3'(len);
      f.fix_status   = status;
      return f;
   endfunction

   // Advance the predictor by one byte; return 1 when the byte closes a sentence.
   function automatic bit parse_rmc_byte(input logic [7:0] chr, output result_type fix);
      logic [3:0] pos;
      bit         done;
      pos  = scan_pos;
      done = 1'b0;
      fix  = '0;
      case (scan_phase)
         PH_HUNT: begin
            if (pos < 6 && chr == RMC_HEADER[pos]) begin
               pos++;
               if (pos == 6) begin
                  wipe_capture();
                  scan_phase = PH_HDRSKIP;
                  pos = '0;
               end
            end else begin
               // A stray '$' counts as the first header character again.
               pos = (chr == CHR_DOLLAR) ? 4'd1 : 4'd0;
            end
         end
         PH_HDRSKIP: begin
            scan_phase = PH_TIME;
            pos = '0;
         end
         PH_TIME: begin
            if (pos < 10) stamp_chars[pos] = chr;
            pos++;
            if (pos >= 10) begin
               scan_phase = PH_TSKIP;
               pos = '0;
            end
         end
         PH_TSKIP: scan_phase = PH_STATUS;
         PH_STATUS: begin
            if (chr == CHR_A) begin
               scan_phase = PH_LATSEP;
            end else begin
               // Anything but 'A' reports at once with empty position fields.
               fix = pack_fix((chr == CHR_V) ? FIX_INVALID : FIX_UNKNOWN);
               done = 1'b1;
               scan_phase = PH_HUNT;
               pos = '0;
            end
         end
         PH_LATSEP: begin
            scan_phase = PH_LAT;
            pos = '0;
         end
         PH_LAT: begin
            if (pos == 4) begin
               if (chr != CHR_POINT) fields_ok = 1'b0;
            end else if (pos < 8) begin
               if (!ascii_digit(chr)) fields_ok = 1'b0;
               lat_nib[(pos < 4) ? pos : pos - 1] = chr[3:0];
            end
            pos++;
            if (pos >= 8) begin
               scan_phase = PH_LONSEP;
               pos = '0;
            end
         end
         PH_LONSEP: begin
            pos++;
            if (pos >= 3) begin
               scan_phase = PH_LON;
               pos = '0;
            end
         end
         PH_LON: begin
            if (pos == 5) begin
               if (chr != CHR_POINT) fields_ok = 1'b0;
            end else if (pos < 9) begin
               if (!ascii_digit(chr)) fields_ok = 1'b0;
               lon_nib[(pos < 5) ? pos : pos - 1] = chr[3:0];
            end
            pos++;
            if (pos >= 9) begin
               scan_phase = PH_SPDSEP;
               pos = '0;
            end
         end
         PH_SPDSEP: begin
            pos++;
            if (pos >= 3) begin
               scan_phase = PH_SPEED;
               pos = '0;
               speed_cnt = '0;
            end
         end
         PH_SPEED: begin
            if (chr == CHR_COMMA) begin
               scan_phase = PH_COURSE;
               pos = '0;
            end else begin
               if (speed_cnt < SPEED_MAX) speed_buf[speed_cnt] = chr;
               speed_cnt++;
               // A full speed field swallows the next byte unchecked.
               if (speed_cnt >= SPEED_MAX) scan_phase = PH_SPDEND;
            end
         end
         PH_SPDEND: begin
            scan_phase = PH_COURSE;
            pos = '0;
         end
         PH_COURSE: begin
            pos++;
            if (chr == CHR_COMMA || pos >= 6) begin
               scan_phase = PH_DATE;
               pos = '0;
            end
         end
         PH_DATE: begin
            if (!ascii_digit(chr)) fields_ok = 1'b0;
            if (pos < 6) date_nib[pos] = chr[3:0];
            pos++;
            if (pos >= 6) begin
               fix = pack_fix(fields_ok ? FIX_VALID : FIX_INVALID);
               done = 1'b1;
               scan_phase = PH_HUNT;
               pos = '0;
            end
         end
         default: begin
            scan_phase = PH_HUNT;
            pos = '0;
         end
      endcase
      scan_pos = pos;
      return done;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus store and sentence builders.
   // ---------------------------------------------------------------------------
   rx_char_type byte_queue [$];
   result_type  expected_fixes [$];
   int          bytes_queued = 0;
   int          bytes_taken = 0;       // advanced with a nonblocking update
   int          fixes_predicted = 0;
   int          fixes_done = 0;        // advanced with a nonblocking update
   int          random_lines = 0;
   int          mismatches = 0;
   int          status_tally [4] = '{0, 0, 0, 0};

   function automatic logic [7:0] rand_digit();
      return CHR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic queue_line(input logic [7:0] line [$], input bit drain_first);
      rx_char_type item;
      foreach (line[k]) begin
         item.chr = line[k];
         item.drain_first = drain_first && (k == 0);
         byte_queue.push_back(item);
      end
      bytes_queued += line.size();
   endtask

   task automatic push_text(input string text, input bit drain_first = 1'b0);
      logic [7:0] line [$];
      for (int k = 0; k < text.len(); k++) line.push_back(text[k]);
      queue_line(line, drain_first);
   endtask

   task automatic put_digits(ref logic [7:0] line [$], input int count);
      repeat (count) line.push_back(rand_digit());
   endtask

   // Build one sentence with random content; mangle damages or truncates it.
   task automatic add_sentence(input logic [7:0] status, input bit mangle,
                               input bit drain_first);
      logic [7:0] line [$];
      int         spd_len;
      int         crs_len;
      int         cut;
      foreach (RMC_HEADER[k]) line.push_back(RMC_HEADER[k]);
      line.push_back(CHR_COMMA);
      // Timestamp is never checked: use raw bytes now and then.
      if ($urandom_range(0, 3) == 0) begin
         repeat (10) line.push_back(8'($urandom_range(0, 255)));
      end else begin
         put_digits(line, 6);
         line.push_back(CHR_POINT);
         put_digits(line, 3);
      end
      line.push_back(CHR_COMMA);
      line.push_back(status);
      line.push_back(CHR_COMMA);
      if (status == CHR_A) begin
         put_digits(line, 4);
         line.push_back(CHR_POINT);
         put_digits(line, 3);
         line.push_back(CHR_COMMA);
         line.push_back($urandom_range(0, 1) ? "N" : "S");
         line.push_back(CHR_COMMA);
         put_digits(line, 5);
         line.push_back(CHR_POINT);
         put_digits(line, 3);
         line.push_back(CHR_COMMA);
         line.push_back($urandom_range(0, 1) ? "E" : "W");
         line.push_back(CHR_COMMA);
         spd_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
         repeat (spd_len) line.push_back(($urandom_range(0, 4) == 0) ? CHR_POINT : rand_digit());
         line.push_back(CHR_COMMA);
         crs_len = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(0, 5);
         repeat (crs_len) line.push_back(($urandom_range(0, 4) == 0) ? CHR_POINT : rand_digit());
         if (crs_len < 6) line.push_back(CHR_COMMA);
         put_digits(line, 6);
      end
      if (mangle) begin
         if ($urandom_range(0, 1)) begin
            line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
         end else begin
            cut = $urandom_range(1, line.size() - 1);
            while (line.size() > cut) void'(line.pop_back());
         end
      end
      random_lines++;
      // Trailing checksum text lands in the header hunt and is ignored.
      if ($urandom_range(0, 4) != 0) begin
         line.push_back(CHR_COMMA);
         line.push_back("*");
         line.push_back(rand_digit());
         line.push_back(rand_digit());
         line.push_back(8'h0D);
         line.push_back(8'h0A);
      end
      queue_line(line, drain_first);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: present queued bytes with random gaps; predict each accepted one.
   // ---------------------------------------------------------------------------
   result_type  parsed_fix;
   rx_char_type next_char;
   int          send_wait = 0;
   bit          sender_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         scan_phase = PH_HUNT;
         scan_pos = '0;
         wipe_capture();
         send_wait = 0;
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bytes_taken <= bytes_taken + 1;
            if (parse_rmc_byte(req_bus.rx_byte, parsed_fix)) begin
               expected_fixes.push_back(parsed_fix);
               fixes_predicted++;
            end
         end
         // Hold the current byte while it is not taken.
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_bus.valid <= 1'b0;
            end else if (byte_queue.size() > 0 &&
                         !(byte_queue[0].drain_first && fixes_done != fixes_predicted)) begin
               next_char = byte_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.rx_byte <= next_char.chr;
               // Switch now and then between gap-free bursts and random gaps.
               if ($urandom_range(0, 63) == 0) sender_burst = !sender_burst;
               send_wait = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: stall the result side at random and check each fix field by field.
   // ---------------------------------------------------------------------------
   result_type want_fix;
   result_type got_fix;
   int         recv_wait = 0;
   bit         recv_burst = 1'b0;

   function automatic void compare_field(input string name, input logic [39:0] want_val,
                                         input logic [39:0] got_val);
      if (want_val !== got_val) begin
         $display("%0t: fix %0d %s expected %h got %h", $time, fixes_done, name,
                  want_val, got_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         recv_wait = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_fix.time_high     = rsp_bus.time_high;
            got_fix.time_low      = rsp_bus.time_low;
            got_fix.latitude_bcd  = rsp_bus.latitude_bcd;
            got_fix.longitude_bcd = rsp_bus.longitude_bcd;
            got_fix.speed_text    = rsp_bus.speed_text;
            got_fix.speed_length  = rsp_bus.speed_length;
            got_fix.date_bcd      = rsp_bus.date_bcd;
            got_fix.fix_status    = rsp_bus.fix_status;
            if (expected_fixes.size() == 0) begin
               $display("%0t: fix with no sentence pending, expected none got status %0d",
                        $time, got_fix.fix_status);
               mismatches++;
            end else begin
               want_fix = expected_fixes.pop_front();
               compare_field("time_high", want_fix.time_high, got_fix.time_high);
               compare_field("time_low", want_fix.time_low, got_fix.time_low);
               compare_field("latitude_bcd", want_fix.latitude_bcd, got_fix.latitude_bcd);
               compare_field("longitude_bcd", want_fix.longitude_bcd, got_fix.longitude_bcd);
               compare_field("speed_text", want_fix.speed_text, got_fix.speed_text);
               compare_field("speed_length", want_fix.speed_length, got_fix.speed_length);
               compare_field("date_bcd", want_fix.date_bcd, got_fix.date_bcd);
               compare_field("fix_status", want_fix.fix_status, got_fix.fix_status);
            end
            fixes_done <= fixes_done + 1;
            status_tally[got_fix.fix_status]++;
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Give up if the run hangs.
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run stopped after %0d cycles, %0d of %0d bytes taken", $time,
                  cycle_count, bytes_taken, bytes_queued);
         $display("[nmea_rmc_field_parser] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: fill the queue, release reset, drain, report.
   // ---------------------------------------------------------------------------
   initial begin
      logic [7:0] raw_stamp [$];
      logic [7:0] odd_status;
      int         pick;
      bit         drain;

      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      reset           = 1'b1;

      // Header hunt with stray dollars, then a void fix.
      push_text("$G$$GPRMC,123519.000,V,,,,,,,,,,N*53\r\n");
      // All-zero fields and an empty speed field.
      push_text("$GPRMC,000000.000,A,0000.000,N,00000.000,E,,,000000,,,A*00\r\n");
      // Extreme byte values in the timestamp and an unknown status character.
      push_text("$GPRMC,");
      raw_stamp = '{8'h00, 8'hFF};
      queue_line(raw_stamp, 1'b0);
      push_text("1234.567,X,\r\n");
      // Largest digits and a five-character speed whose comma is swallowed.
      push_text("$GPRMC,235959.999,A,9959.999,S,17959.999,W,12.34,359.9,311299,,,A*6A\r\n");
      // Bad digits and points in latitude, longitude and date.
      push_text("$GPRMC,101010.100,A,12a4x567,N,01234,567,E,9,,010a20\r\n");
      // Overlong speed field; send only once every fix is back.
      push_text("$GPRMC,111111.111,A,4807.038,N,01131.000,E,12345678,150699\r\n", 1'b1);
      // A dollar in the timestamp and a header inside a six-byte course: no restart.
      push_text("$GPRMC,12$456.789,A,4807.038,N,01131.000,E,1.5,$GPRMC150699\r\n");

      // Random part: mostly well-formed sentences, plus broken ones and noise.
      while (bytes_queued < STREAM_BYTES || random_lines < RANDOM_LINES) begin
         pick  = $urandom_range(0, 99);
         drain = ($urandom_range(0, 24) == 0);
         if (pick < 55) begin
            add_sentence(CHR_A, 1'b0, drain);
         end else if (pick < 68) begin
            add_sentence(CHR_V, 1'b0, drain);
         end else if (pick < 73) begin
            do odd_status = 8'($urandom_range(0, 255));
            while (odd_status == CHR_A || odd_status == CHR_V);
            add_sentence(odd_status, 1'b0, drain);
         end else if (pick < 88) begin
            add_sentence(CHR_A, 1'b1, drain);
         end else begin
            // Line noise, seeded with header characters to tease the hunt.
            raw_stamp.delete();
            repeat ($urandom_range(1, 16)) begin
               if ($urandom_range(0, 3) == 0) begin
                  raw_stamp.push_back(RMC_HEADER[$urandom_range(0, 5)]);
               end else begin
                  raw_stamp.push_back(8'($urandom_range(0, 255)));
               end
            end
            queue_line(raw_stamp, drain);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to go in and every predicted fix to come out.
      while (bytes_taken < bytes_queued || fixes_done < fixes_predicted) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Parsed %0d bytes into %0d fixes: %0d valid, %0d invalid, %0d unknown status.",
               bytes_taken, fixes_done, status_tally[FIX_VALID], status_tally[FIX_INVALID],
               status_tally[FIX_UNKNOWN]);
      $display("Stream mixed clean, damaged and truncated sentences with noise and stalls.");
      if (mismatches == 0) begin
         $display("[nmea_rmc_field_parser] OK");
      end else begin
         $display("[nmea_rmc_field_parser] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/nrmc_pkg.sv
design/nrmc_if.sv
design/nrmc_parser.sv
design/nrmc_result_reg.sv
design/nmea_rmc_field_parser.sv
tb/tb_top.sv
